// File: sv/mfb_pkg.sv
package mfb_pkg;

   localparam int PANEL_WIDTH  = 1024;
   localparam int PANEL_HEIGHT = 512;
   localparam int PITCH        = (PANEL_WIDTH + 7) / 8;

   localparam int STORE_DEPTH = 65536;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   localparam int CMD_DEPTH  = 4;
   localparam int CMD_PTR_W  = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_W  = $clog2(CMD_DEPTH + 1);
   localparam int RSP_DEPTH  = 8;
   localparam int RSP_PTR_W  = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W  = $clog2(RSP_DEPTH + 1);

   localparam logic [7:0] THRESHOLD_RESET = 8'd128;
   localparam logic [8:0] FULL_ROW_LAST   = 9'(PANEL_HEIGHT - 1);

   localparam logic [1:0] KIND_PIXEL   = 2'd0;
   localparam logic [1:0] KIND_FLUSH   = 2'd1;
   localparam logic [1:0] KIND_REQUEST = 2'd2;

   localparam logic [2:0] ACT_WRITE   = 3'd0;
   localparam logic [2:0] ACT_DROP    = 3'd1;
   localparam logic [2:0] ACT_FULL    = 3'd2;
   localparam logic [2:0] ACT_PARTIAL = 3'd3;
   localparam logic [2:0] ACT_NONE    = 3'd4;
   localparam logic [2:0] ACT_NOTED   = 3'd5;

   typedef enum logic [1:0] {
      OP_WRITE,
      OP_DROP,
      OP_FLUSH,
      OP_REQUEST
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [ADDR_W-1:0]   addr;
      logic [7:0]          mask;
      logic                white;
      logic [8:0]          row;
   } cmd_type;

   typedef struct packed {
      logic [2:0]          action;
      logic [ADDR_W-1:0]   byte_address;
      logic [7:0]          byte_value;
      logic [8:0]          row_first;
      logic [8:0]          row_last;
   } rsp_type;

endpackage

// File: sv/mfb_front.sv
module mfb_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   input  logic [7:0]             csr_gray_threshold,
   input  logic [1:0]             req_kind,
   input  logic signed [12:0]     req_pixel_x,
   input  logic signed [12:0]     req_pixel_y,
   input  logic [15:0]            req_color,
   output mfb_pkg::cmd_type       cmd
);
   import mfb_pkg::*;

   logic [7:0]  threshold_ff;
   logic [7:0]  threshold_in;
   logic [7:0]  r8;
   logic [7:0]  g8;
   logic [7:0]  b8;
   logic [15:0] luma_sum;
   logic        off_panel;
   logic [31:0] addr_full;

   assign threshold_in = csr_valid ? csr_gray_threshold : threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
      end else begin
         threshold_ff <= threshold_in;
      end
   end

   // widen each channel by bit replication, then weighted luma
   assign r8 = {req_color[15:11], req_color[15:13]};
   assign g8 = {req_color[10:5], req_color[10:9]};
   assign b8 = {req_color[4:0], req_color[4:2]};
   assign luma_sum = 16'(16'(r8) * 16'd76 + 16'(g8) * 16'd150 + 16'(b8) * 16'd30);

   assign off_panel = req_pixel_x[12] || req_pixel_y[12]
                   || ({1'b0, req_pixel_x[11:0]} >= 13'(PANEL_WIDTH))
                   || ({1'b0, req_pixel_y[11:0]} >= 13'(PANEL_HEIGHT));

   assign addr_full = 32'(req_pixel_y[11:0]) * 32'(PITCH) + 32'(req_pixel_x[11:3]);

   always_comb begin
      cmd.addr  = addr_full[ADDR_W-1:0];
      cmd.mask  = 8'h80 >> req_pixel_x[2:0];
      cmd.white = (luma_sum[15:8] >= threshold_ff);
      cmd.row   = req_pixel_y[8:0];
      case (req_kind)
         KIND_PIXEL:   cmd.op = off_panel ? OP_DROP : OP_WRITE;
         KIND_FLUSH:   cmd.op = OP_FLUSH;
         KIND_REQUEST: cmd.op = OP_REQUEST;
         default:      cmd.op = OP_DROP;
      endcase
   end

endmodule

// File: sv/mfb_cmd_queue.sv
module mfb_cmd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  mfb_pkg::cmd_type   push_data,
   output logic               full,
   input  logic               pop,
   output mfb_pkg::cmd_type   head,
   output logic               empty
);
   import mfb_pkg::*;

   cmd_type                entry_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0]   wr_ptr_ff;
   logic [CMD_PTR_W-1:0]   wr_ptr_in;
   logic [CMD_PTR_W-1:0]   rd_ptr_ff;
   logic [CMD_PTR_W-1:0]   rd_ptr_in;
   logic [CMD_CNT_W-1:0]   count_ff;
   logic [CMD_CNT_W-1:0]   count_in;
   logic                   do_push;
   logic                   do_pop;

   assign full    = (count_ff == CMD_CNT_W'(CMD_DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? CMD_PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? CMD_PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = CMD_CNT_W'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = CMD_CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: sv/mfb_back.sv
module mfb_back (
   input  logic                      clock,
   input  logic                      reset,
   input  mfb_pkg::cmd_type          cmd_head,
   input  logic                      cmd_empty,
   output logic                      cmd_pop,
   input  logic [mfb_pkg::RSP_CNT_W-1:0] rsp_count,
   output logic                      rsp_push,
   output mfb_pkg::rsp_type          rsp_data,
   output logic                      busy
);
   import mfb_pkg::*;

   logic [7:0]          store [STORE_DEPTH];
   logic [7:0]          rd_data_ff;

   logic                clearing_ff;
   logic                clearing_in;
   logic [ADDR_W-1:0]   clear_addr_ff;
   logic [ADDR_W-1:0]   clear_addr_in;

   logic                stage_valid_ff;
   cmd_type             stage_cmd_ff;

   logic                fwd_valid_ff;
   logic [ADDR_W-1:0]   fwd_addr_ff;
   logic [7:0]          fwd_data_ff;

   logic [8:0]          dirty_min_ff;
   logic [8:0]          dirty_min_in;
   logic [8:0]          dirty_max_ff;
   logic [8:0]          dirty_max_in;
   logic                rows_dirty_ff;
   logic                rows_dirty_in;
   logic                full_pending_ff;
   logic                full_pending_in;

   logic [7:0]          cur_byte;
   logic [7:0]          new_byte;
   logic                wr_en;
   logic [RSP_CNT_W:0]  in_flight;

   assign busy      = clearing_ff;
   assign in_flight = (RSP_CNT_W + 1)'(rsp_count) + (RSP_CNT_W + 1)'(stage_valid_ff);
   assign cmd_pop   = !clearing_ff && !cmd_empty
                   && (in_flight < (RSP_CNT_W + 1)'(RSP_DEPTH));

   // clearing pass fills the store with white after reset
   always_comb begin
      clear_addr_in = ADDR_W'(clear_addr_ff + 1'b1);
      clearing_in   = clearing_ff && (clear_addr_ff != '1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff   <= 1'b1;
         clear_addr_ff <= '0;
      end else if (clearing_ff) begin
         clearing_ff   <= clearing_in;
         clear_addr_ff <= clear_addr_in;
      end
   end

   // read-modify-write with forwarding of the previous write
   assign cur_byte = (fwd_valid_ff && fwd_addr_ff == stage_cmd_ff.addr) ? fwd_data_ff
                                                                       : rd_data_ff;
   assign new_byte = stage_cmd_ff.white ? (cur_byte | stage_cmd_ff.mask)
                                        : (cur_byte & ~stage_cmd_ff.mask);
   assign wr_en    = stage_valid_ff && (stage_cmd_ff.op == OP_WRITE);

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         store[clear_addr_ff] <= 8'hFF;
      end else if (wr_en) begin
         store[stage_cmd_ff.addr] <= new_byte;
      end
      rd_data_ff <= store[cmd_head.addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         fwd_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= cmd_pop;
         fwd_valid_ff   <= wr_en;
      end
   end

   always_ff @(posedge clock) begin
      stage_cmd_ff <= cmd_head;
      fwd_addr_ff  <= stage_cmd_ff.addr;
      fwd_data_ff  <= new_byte;
   end

   always_comb begin
      dirty_min_in    = dirty_min_ff;
      dirty_max_in    = dirty_max_ff;
      rows_dirty_in   = rows_dirty_ff;
      full_pending_in = full_pending_ff;
      rsp_data        = '0;
      rsp_data.action = ACT_DROP;
      case (stage_cmd_ff.op)
         OP_WRITE: begin
            rsp_data.action       = ACT_WRITE;
            rsp_data.byte_address = stage_cmd_ff.addr;
            rsp_data.byte_value   = new_byte;
            rows_dirty_in         = 1'b1;
            if (!rows_dirty_ff || stage_cmd_ff.row < dirty_min_ff) begin
               dirty_min_in = stage_cmd_ff.row;
            end
            if (!rows_dirty_ff || stage_cmd_ff.row > dirty_max_ff) begin
               dirty_max_in = stage_cmd_ff.row;
            end
         end
         OP_FLUSH: begin
            if (full_pending_ff) begin
               rsp_data.action   = ACT_FULL;
               rsp_data.row_last = FULL_ROW_LAST;
               full_pending_in   = 1'b0;
            end else if (rows_dirty_ff) begin
               rsp_data.action    = ACT_PARTIAL;
               rsp_data.row_first = dirty_min_ff;
               rsp_data.row_last  = dirty_max_ff;
            end else begin
               rsp_data.action = ACT_NONE;
            end
            rows_dirty_in = 1'b0;
            dirty_min_in  = '0;
            dirty_max_in  = '0;
         end
         OP_REQUEST: begin
            rsp_data.action = ACT_NOTED;
            full_pending_in = 1'b1;
         end
         default: begin
            rsp_data.action = ACT_DROP;
         end
      endcase
   end

   assign rsp_push = stage_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dirty_min_ff    <= '0;
         dirty_max_ff    <= '0;
         rows_dirty_ff   <= 1'b0;
         full_pending_ff <= 1'b1;
      end else if (stage_valid_ff) begin
         dirty_min_ff    <= dirty_min_in;
         dirty_max_ff    <= dirty_max_in;
         rows_dirty_ff   <= rows_dirty_in;
         full_pending_ff <= full_pending_in;
      end
   end

endmodule

// File: sv/mfb_rsp_queue.sv
module mfb_rsp_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  mfb_pkg::rsp_type              push_data,
   input  logic                          pop,
   output mfb_pkg::rsp_type              head,
   output logic                          empty,
   output logic [mfb_pkg::RSP_CNT_W-1:0] count
);
   import mfb_pkg::*;

   rsp_type                entry_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]   wr_ptr_ff;
   logic [RSP_PTR_W-1:0]   wr_ptr_in;
   logic [RSP_PTR_W-1:0]   rd_ptr_ff;
   logic [RSP_PTR_W-1:0]   rd_ptr_in;
   logic [RSP_CNT_W-1:0]   count_ff;
   logic [RSP_CNT_W-1:0]   count_in;
   logic                   do_pop;

   assign empty  = (count_ff == '0);
   assign count  = count_ff;
   assign head   = entry_ff[rd_ptr_ff];
   assign do_pop = pop && !empty;

   always_comb begin
      wr_ptr_in = push ? RSP_PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? RSP_PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = RSP_CNT_W'(count_ff + 1'b1);
      end else if (do_pop && !push) begin
         count_in = RSP_CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: sv/rgb565_to_mono_framebuffer_unit.sv
// channel   direction  handshake                 payload
// req_      in         push / full               kind, pixel_x, pixel_y, color
// rsp_      out        empty / pop               action, byte_address, byte_value,
//                                                row_first, row_last
// csr_      in         valid / ready (always 1)  gray_threshold
//
// one item per cycle sustained while the result queue has room; a result shows on rsp_ after
// its item passes the command queue, the stage register and the result queue. the rate is set
// by the framebuffer read-modify-write, with the last write forwarded to the next item.
// after reset a clearing pass over all 65536 bytes whitens the framebuffer; req_full is high
// throughout. a stalled result side fills the result queue, then the command queue, then
// raises req_full.
module rgb565_to_mono_framebuffer_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  logic [1:0]          req_kind,
   input  logic signed [12:0]  req_pixel_x,
   input  logic signed [12:0]  req_pixel_y,
   input  logic [15:0]         req_color,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic [2:0]          rsp_action,
   output logic [15:0]         rsp_byte_address,
   output logic [7:0]          rsp_byte_value,
   output logic [8:0]          rsp_row_first,
   output logic [8:0]          rsp_row_last,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [7:0]          csr_gray_threshold
);
   import mfb_pkg::*;

   cmd_type                front_cmd;
   cmd_type                cmd_head;
   logic                   cmd_full;
   logic                   cmd_empty;
   logic                   cmd_pop;
   logic                   back_busy;
   logic                   rsp_push;
   rsp_type                rsp_push_data;
   rsp_type                rsp_head;
   logic [RSP_CNT_W-1:0]   rsp_count;

   assign csr_ready = 1'b1;
   assign req_full  = cmd_full || back_busy;

   mfb_front u_front (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_gray_threshold (csr_gray_threshold),
      .req_kind           (req_kind),
      .req_pixel_x        (req_pixel_x),
      .req_pixel_y        (req_pixel_y),
      .req_color          (req_color),
      .cmd                (front_cmd)
   );

   mfb_cmd_queue u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push && !req_full),
      .push_data (front_cmd),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .head      (cmd_head),
      .empty     (cmd_empty)
   );

   mfb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_head  (cmd_head),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp_count (rsp_count),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_push_data),
      .busy      (back_busy)
   );

   mfb_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_push_data),
      .pop       (rsp_pop),
      .head      (rsp_head),
      .empty     (rsp_empty),
      .count     (rsp_count)
   );

   assign rsp_action       = rsp_head.action;
   assign rsp_byte_address = rsp_head.byte_address;
   assign rsp_byte_value   = rsp_head.byte_value;
   assign rsp_row_first    = rsp_head.row_first;
   assign rsp_row_last     = rsp_head.row_last;

endmodule
